[design/ftws_pkg.sv]
package ftws_pkg;

  localparam int WINDOW       = 64;
  localparam int DATA_W       = 32;
  localparam int FPS_W        = 20;
  localparam int BW_W         = DATA_W + FPS_W;
  localparam int PTR_W        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W       = $clog2(WINDOW + 1);
  localparam int SUM_W        = DATA_W + $clog2(WINDOW);
  localparam int CNT_W        = $clog2(SUM_W);
  localparam int ENTRY_W      = 3 * DATA_W;
  localparam int USEC_PER_SEC = 1000000;

endpackage

[design/ftws_if.sv]
interface ftws_in_if;
  import ftws_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] frame_time;
  logic [DATA_W-1:0] dirty_area;
  logic [DATA_W-1:0] copy_bytes;
  logic [DATA_W-1:0] frame_tag;

  modport source (output valid, frame_time, dirty_area, copy_bytes, frame_tag, input ready);
  modport sink (input valid, frame_time, dirty_area, copy_bytes, frame_tag, output ready);
endinterface

interface ftws_out_if;
  import ftws_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] mean_time;
  logic [DATA_W-1:0] mean_area;
  logic [DATA_W-1:0] mean_bytes;
  logic [FPS_W-1:0]  frames_per_second;
  logic [BW_W-1:0]   bandwidth;
  logic [DATA_W-1:0] worst_time;
  logic [DATA_W-1:0] worst_tag;
  logic [DATA_W-1:0] best_time;
  logic [DATA_W-1:0] best_tag;
  logic [DATA_W-1:0] frame_total;

  modport source (output valid, mean_time, mean_area, mean_bytes, frames_per_second,
                  bandwidth, worst_time, worst_tag, best_time, best_tag, frame_total,
                  input ready);
  modport sink (input valid, mean_time, mean_area, mean_bytes, frames_per_second,
                bandwidth, worst_time, worst_tag, best_time, best_tag, frame_total,
                output ready);
endinterface

[design/frame_time_window_stats.sv]
// channel   dir  modport  payload
// in_word   in   sink     frame_time, dirty_area, copy_bytes, frame_tag
// out_word  out  source   mean_time, mean_area, mean_bytes, frames_per_second,
//                         bandwidth, worst_time, worst_tag, best_time, best_tag,
//                         frame_total
//
// Each word passes through the shared bit-serial divider (four quotients) and
// then the serial multiplier; no new word is taken until that word is done.
// Reset clears counters and sums at once; the ring has no clearing pass.
// A finished word waits in the output register while the next word is taken;
// the block then holds in its done state until the output register is free.
module frame_time_window_stats (
  input  logic       clk,
  input  logic       rst_n,
  ftws_in_if.sink    in_word,
  ftws_out_if.source out_word
);
  import ftws_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SUB, S_LOAD, S_DIV, S_MUL, S_DONE} state_t;
  typedef enum logic [1:0] {OP_TIME, OP_AREA, OP_BYTES, OP_RATE} op_t;

  state_t            state_r;
  op_t               op_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [PTR_W-1:0]  pos_r;
  logic [FILL_W-1:0] fill_r;
  logic              sub_en_r;
  logic [SUM_W-1:0]  time_sum_r, area_sum_r, bytes_sum_r;
  logic [DATA_W-1:0] frame_cnt_r;
  logic [DATA_W-1:0] worst_time_r, worst_tag_r, best_time_r, best_tag_r;

  logic [SUM_W-1:0]  dvd_r;
  logic [DATA_W-1:0] dvs_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] mt_r, ma_r, mb_r;
  logic [FPS_W-1:0]  fps_r;
  logic [DATA_W-1:0] hi_r;
  logic [FPS_W-1:0]  lo_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] o_mt_r, o_ma_r, o_mb_r;
  logic [FPS_W-1:0]  o_fps_r;
  logic [BW_W-1:0]   o_bw_r;
  logic [DATA_W-1:0] o_wt_r, o_wg_r, o_bt_r, o_bg_r, o_cnt_r;

  logic [ENTRY_W-1:0] ring_mem [WINDOW];
  logic [ENTRY_W-1:0] old_entry_r;

  logic              accept;
  logic              first;
  logic              full;
  logic              out_load;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [DATA_W-1:0] rem_nxt;
  logic [SUM_W-1:0]  dvd_nxt;
  logic [DATA_W:0]   mul_add;
  logic [SUM_W-1:0]  load_dvd;
  logic [DATA_W-1:0] load_dvs;

  assign accept = in_word.valid && in_word.ready;
  assign in_word.ready = (state_r == S_IDLE);
  assign first = (frame_cnt_r == '0);
  assign full = (fill_r == FILL_W'(WINDOW));
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_word.ready);

  assign rem_sh  = {rem_r, dvd_r[SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign rem_nxt = ge ? DATA_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DATA_W-1:0];
  assign dvd_nxt = {dvd_r[SUM_W-2:0], ge};
  assign mul_add = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mb_r} : '0);

  always_comb begin
    case (op_r)
      OP_TIME: begin
        load_dvd = time_sum_r;
        load_dvs = DATA_W'(fill_r);
      end
      OP_AREA: begin
        load_dvd = area_sum_r;
        load_dvs = DATA_W'(fill_r);
      end
      OP_BYTES: begin
        load_dvd = bytes_sum_r;
        load_dvs = DATA_W'(fill_r);
      end
      OP_RATE: begin
        load_dvd = SUM_W'(USEC_PER_SEC);
        load_dvs = mt_r;
      end
      default: begin
        load_dvd = '0;
        load_dvs = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring_mem[pos_r] <= {in_word.frame_time, in_word.dirty_area, in_word.copy_bytes};
      old_entry_r     <= ring_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_TIME;
      cnt_r        <= '0;
      pos_r        <= '0;
      fill_r       <= '0;
      sub_en_r     <= 1'b0;
      time_sum_r   <= '0;
      area_sum_r   <= '0;
      bytes_sum_r  <= '0;
      frame_cnt_r  <= '0;
      worst_time_r <= '0;
      worst_tag_r  <= '0;
      best_time_r  <= '0;
      best_tag_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (frame_cnt_r != '1) frame_cnt_r <= frame_cnt_r + 1'b1;
            if (first || in_word.frame_time > worst_time_r) begin
              worst_time_r <= in_word.frame_time;
              worst_tag_r  <= in_word.frame_tag;
            end
            if (first || in_word.frame_time < best_time_r) begin
              best_time_r <= in_word.frame_time;
              best_tag_r  <= in_word.frame_tag;
            end
            sub_en_r    <= full;
            if (!full) fill_r <= fill_r + 1'b1;
            pos_r       <= (pos_r == PTR_W'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
            time_sum_r  <= time_sum_r + SUM_W'(in_word.frame_time);
            area_sum_r  <= area_sum_r + SUM_W'(in_word.dirty_area);
            bytes_sum_r <= bytes_sum_r + SUM_W'(in_word.copy_bytes);
            state_r     <= S_SUB;
          end
        end
        S_SUB: begin
          if (sub_en_r) begin
            time_sum_r  <= time_sum_r - SUM_W'(old_entry_r[3*DATA_W-1:2*DATA_W]);
            area_sum_r  <= area_sum_r - SUM_W'(old_entry_r[2*DATA_W-1:DATA_W]);
            bytes_sum_r <= bytes_sum_r - SUM_W'(old_entry_r[DATA_W-1:0]);
          end
          op_r    <= OP_TIME;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          dvd_r   <= load_dvd;
          dvs_r   <= load_dvs;
          rem_r   <= '0;
          cnt_r   <= CNT_W'(SUM_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          dvd_r <= dvd_nxt;
          rem_r <= rem_nxt;
          if (cnt_r == '0) begin
            case (op_r)
              OP_TIME: begin
                mt_r    <= dvd_nxt[DATA_W-1:0];
                op_r    <= OP_AREA;
                state_r <= S_LOAD;
              end
              OP_AREA: begin
                ma_r    <= dvd_nxt[DATA_W-1:0];
                op_r    <= OP_BYTES;
                state_r <= S_LOAD;
              end
              OP_BYTES: begin
                mb_r    <= dvd_nxt[DATA_W-1:0];
                op_r    <= OP_RATE;
                state_r <= S_LOAD;
              end
              default: begin
                fps_r   <= (mt_r == '0) ? '0 : dvd_nxt[FPS_W-1:0];
                hi_r    <= '0;
                lo_r    <= (mt_r == '0) ? '0 : dvd_nxt[FPS_W-1:0];
                cnt_r   <= CNT_W'(FPS_W - 1);
                state_r <= S_MUL;
              end
            endcase
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_MUL: begin
          hi_r  <= mul_add[DATA_W:1];
          lo_r  <= {mul_add[0], lo_r[FPS_W-1:1]};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            o_mt_r      <= mt_r;
            o_ma_r      <= ma_r;
            o_mb_r      <= mb_r;
            o_fps_r     <= fps_r;
            o_bw_r      <= {hi_r, lo_r};
            o_wt_r      <= worst_time_r;
            o_wg_r      <= worst_tag_r;
            o_bt_r      <= best_time_r;
            o_bg_r      <= best_tag_r;
            o_cnt_r     <= frame_cnt_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_word.valid             = out_valid_r;
  assign out_word.mean_time         = o_mt_r;
  assign out_word.mean_area         = o_ma_r;
  assign out_word.mean_bytes        = o_mb_r;
  assign out_word.frames_per_second = o_fps_r;
  assign out_word.bandwidth         = o_bw_r;
  assign out_word.worst_time        = o_wt_r;
  assign out_word.worst_tag         = o_wg_r;
  assign out_word.best_time         = o_bt_r;
  assign out_word.best_tag          = o_bg_r;
  assign out_word.frame_total       = o_cnt_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("fill level beyond window");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_word.ready)
    else $error("input taken while busy");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  a_best_le_worst: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_cnt_r != '0) |-> (best_time_r <= worst_time_r))
    else $error("best time above worst time");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_cnt_r != '0))
    else $error("result with zero frame count");

endmodule

[tb/sv/tb_frame_time_window_stats.sv]
module tb_frame_time_window_stats;
  timeunit 1ns;
  timeprecision 1ps;

  import ftws_pkg::*;

  localparam int ITEMS_PER_PHASE = 213;
  localparam int HOLD_CYCLES     = 1500;
  localparam int DRAIN_CYCLES    = 400;
  localparam int QUIET_LIMIT     = 20000;

  typedef struct packed {
    logic [DATA_W-1:0] frame_time;
    logic [DATA_W-1:0] dirty_area;
    logic [DATA_W-1:0] copy_bytes;
    logic [DATA_W-1:0] frame_tag;
  } frame_rec_t;

  typedef struct packed {
    logic [DATA_W-1:0] mean_time;
    logic [DATA_W-1:0] mean_area;
    logic [DATA_W-1:0] mean_bytes;
    logic [FPS_W-1:0]  fps;
    logic [BW_W-1:0]   bandwidth;
    logic [DATA_W-1:0] worst_time;
    logic [DATA_W-1:0] worst_tag;
    logic [DATA_W-1:0] best_time;
    logic [DATA_W-1:0] best_tag;
    logic [DATA_W-1:0] frame_total;
  } frame_stats_t;

  typedef struct packed {
    frame_rec_t   rec;
    logic         has_want;
    frame_stats_t want;
  } stim_row_t;

  typedef enum int {
    LOAD_ANY,
    LOAD_TINY,
    LOAD_TYPICAL,
    LOAD_HUGE,
    LOAD_CORNER,
    LOAD_ONE_FPS
  } load_style_e;

  logic clk;
  logic rst_n;

  ftws_in_if  in_word();
  ftws_out_if out_word();

  frame_time_window_stats dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  int           err_cnt = 0;
  int           src_idle_pct;
  int           sink_idle_pct;
  int           hold_request = 0;
  frame_stats_t pending_stats[$];

  logic [DATA_W-1:0] time_hist [WINDOW];
  logic [DATA_W-1:0] area_hist [WINDOW];
  logic [DATA_W-1:0] bytes_hist[WINDOW];
  int unsigned       hist_slot   = 0;
  int unsigned       hist_filled = 0;
  logic [SUM_W-1:0]  time_acc    = '0;
  logic [SUM_W-1:0]  area_acc    = '0;
  logic [SUM_W-1:0]  bytes_acc   = '0;
  logic [DATA_W-1:0] seen_frames = '0;
  logic [DATA_W-1:0] worst_t     = '0;
  logic [DATA_W-1:0] worst_id    = '0;
  logic [DATA_W-1:0] best_t      = '0;
  logic [DATA_W-1:0] best_id     = '0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic frame_stats_t advance_frame_stats(frame_rec_t r);
    frame_stats_t s;
    logic         first;
    first = (seen_frames == '0);
    if (seen_frames != '1) seen_frames++;
    if (hist_filled >= WINDOW) begin
      time_acc  -= SUM_W'(time_hist[hist_slot]);
      area_acc  -= SUM_W'(area_hist[hist_slot]);
      bytes_acc -= SUM_W'(bytes_hist[hist_slot]);
    end else begin
      hist_filled++;
    end
    time_hist[hist_slot]  = r.frame_time;
    area_hist[hist_slot]  = r.dirty_area;
    bytes_hist[hist_slot] = r.copy_bytes;
    time_acc  += SUM_W'(r.frame_time);
    area_acc  += SUM_W'(r.dirty_area);
    bytes_acc += SUM_W'(r.copy_bytes);
    hist_slot = (hist_slot + 1 >= WINDOW) ? 0 : hist_slot + 1;

    s.mean_time  = DATA_W'(time_acc / SUM_W'(hist_filled));
    s.mean_area  = DATA_W'(area_acc / SUM_W'(hist_filled));
    s.mean_bytes = DATA_W'(bytes_acc / SUM_W'(hist_filled));
    s.fps        = (s.mean_time != '0) ? FPS_W'(32'(USEC_PER_SEC) / s.mean_time) : '0;
    s.bandwidth  = BW_W'(s.mean_bytes) * BW_W'(s.fps);

    if (first || r.frame_time > worst_t) begin
      worst_t  = r.frame_time;
      worst_id = r.frame_tag;
    end
    if (first || r.frame_time < best_t) begin
      best_t  = r.frame_time;
      best_id = r.frame_tag;
    end
    s.worst_time  = worst_t;
    s.worst_tag   = worst_id;
    s.best_time   = best_t;
    s.best_tag    = best_id;
    s.frame_total = seen_frames;
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] corner_word();
    case ($urandom_range(3))
      0: return '0;
      1: return 1;
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic frame_rec_t draw_frame(load_style_e style);
    frame_rec_t r;
    r.frame_time = $urandom;
    r.dirty_area = $urandom;
    r.copy_bytes = $urandom;
    r.frame_tag  = $urandom;
    case (style)
      LOAD_TINY: begin
        r.frame_time = $urandom_range(3);
        if ($urandom_range(1)) r.copy_bytes = 32'hFFFF_FFFF - $urandom_range(15);
      end
      LOAD_TYPICAL: begin
        r.frame_time = $urandom_range(50000, 8000);
        r.dirty_area = $urandom_range(2000000);
        r.copy_bytes = $urandom_range(8000000);
      end
      LOAD_HUGE: begin
        r.frame_time = 32'hFFFF_FFFF - $urandom_range(1000);
        r.dirty_area = 32'hFFFF_FFFF - $urandom_range(1000);
        r.copy_bytes = 32'hFFFF_FFFF - $urandom_range(1000);
      end
      LOAD_CORNER: begin
        r.frame_time = corner_word();
        r.dirty_area = corner_word();
        r.copy_bytes = corner_word();
        r.frame_tag  = corner_word();
      end
      LOAD_ONE_FPS: begin
        r.frame_time = $urandom_range(1000001, 999000);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_word(frame_rec_t r, logic has_want, frame_stats_t want);
    frame_stats_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_word.valid <= 1'b0;
      @(negedge clk);
    end
    in_word.valid      <= 1'b1;
    in_word.frame_time <= r.frame_time;
    in_word.dirty_area <= r.dirty_area;
    in_word.copy_bytes <= r.copy_bytes;
    in_word.frame_tag  <= r.frame_tag;
    do @(posedge clk); while (!in_word.ready);
    predicted = advance_frame_stats(r);
    pending_stats.push_back(has_want ? want : predicted);
  endtask

  initial begin : stimulus
    stim_row_t   rows[$];
    load_style_e style;
    int          left;
    int          run_len;

    rst_n              = 1'b0;
    in_word.valid      = 1'b0;
    in_word.frame_time = '0;
    in_word.dirty_area = '0;
    in_word.copy_bytes = '0;
    in_word.frame_tag  = '0;

    // first frame: zero time, zero means, sets best and worst
    rows.push_back('{rec: '{32'h0, 32'h0, 32'h0, 32'h11}, has_want: 1'b1,
                     want: '{32'h0, 32'h0, 32'h0, 20'h0, 52'h0,
                             32'h0, 32'h11, 32'h0, 32'h11, 32'h1}});
    rows.push_back('{rec: '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                     has_want: 1'b1,
                     want: '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'h0, 52'h0,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h11, 32'h2}});
    // ties keep the older tag
    rows.push_back('{rec: '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h22}, has_want: 1'b0, want: '0});
    rows.push_back('{rec: '{32'h0, 32'h0, 32'h0, 32'h33}, has_want: 1'b0, want: '0});
    rows.push_back('{rec: '{32'h1, 32'h1, 32'h1, 32'h44}, has_want: 1'b0, want: '0});
    rows.push_back('{rec: '{32'd1000000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555},
                     has_want: 1'b0, want: '0});
    rows.push_back('{rec: '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA},
                     has_want: 1'b0, want: '0});
    rows.push_back('{rec: '{32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0},
                     has_want: 1'b0, want: '0});
    rows.push_back('{rec: '{32'd999999, 32'h0, 32'd12345678, 32'h0000_FFFF},
                     has_want: 1'b0, want: '0});
    rows.push_back('{rec: '{32'h8000_0000, 32'h1, 32'h0, 32'hFFFF_0000},
                     has_want: 1'b0, want: '0});
    rows.push_back('{rec: '{32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678},
                     has_want: 1'b0, want: '0});

    src_idle_pct  = 32;
    sink_idle_pct = 74;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) push_word(rows[i].rec, rows[i].has_want, rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 32;
          sink_idle_pct = 74;
        end
        1: begin
          src_idle_pct  = 74;
          sink_idle_pct = 32;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          hold_request  = HOLD_CYCLES;
        end
      endcase
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        style   = load_style_e'($urandom_range(LOAD_ONE_FPS));
        run_len = $urandom_range(90, 1);
        if (run_len > left) run_len = left;
        repeat (run_len) push_word(draw_frame(style), 1'b0, '0);
        left -= run_len;
      end
    end

    @(negedge clk);
    in_word.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    int hold_left;
    hold_left      = 0;
    out_word.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_word.ready <= 1'b0;
        hold_left--;
      end else begin
        out_word.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic void cmp_field(string fld, logic [BW_W-1:0] want, logic [BW_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    frame_stats_t want;
    if (rst_n && out_word.valid && out_word.ready) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual mean_time %0h",
                 $time, out_word.mean_time);
        err_cnt++;
      end else begin
        want = pending_stats.pop_front();
        cmp_field("mean_time", BW_W'(want.mean_time), BW_W'(out_word.mean_time));
        cmp_field("mean_area", BW_W'(want.mean_area), BW_W'(out_word.mean_area));
        cmp_field("mean_bytes", BW_W'(want.mean_bytes), BW_W'(out_word.mean_bytes));
        cmp_field("frames_per_second", BW_W'(want.fps),
                  BW_W'(out_word.frames_per_second));
        cmp_field("bandwidth", want.bandwidth, out_word.bandwidth);
        cmp_field("worst_time", BW_W'(want.worst_time), BW_W'(out_word.worst_time));
        cmp_field("worst_tag", BW_W'(want.worst_tag), BW_W'(out_word.worst_tag));
        cmp_field("best_time", BW_W'(want.best_time), BW_W'(out_word.best_time));
        cmp_field("best_tag", BW_W'(want.best_tag), BW_W'(out_word.best_tag));
        cmp_field("frame_total", BW_W'(want.frame_total), BW_W'(out_word.frame_total));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[frame_time_window_stats.f]
design/ftws_pkg.sv
design/ftws_if.sv
design/frame_time_window_stats.sv
tb/sv/tb_frame_time_window_stats.sv
